/* sv/ptom_pkg.sv */
// ============================================================================
// ptom_pkg - shared types and codes of the price-time order matcher
// field widths, mode and status codes, table entry layout, sequencer states
// ============================================================================
package ptom_pkg;

    localparam int BOOK_DEPTH_DEF = 16;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 31;
    localparam int PRICE_W  = 32;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;

    localparam logic [MODE_W-1:0] MODE_BUY    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SELL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_RESTED    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_MATCHED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_CANCELLED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]    ident;
        logic [PRICE_W-1:0] price;
        logic [TIME_W-1:0]  stamp;
    } t_entry;

    typedef enum logic [1:0] {
        CMP_ASK,
        CMP_BID,
        CMP_ID
    } t_cmp_op;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic inc;
        logic dec;
    } t_tbl_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DECIDE,
        ST_COMPACT,
        ST_DONE
    } t_state;

endpackage

/* sv/ptom_if.sv */
// ============================================================================
// ptom_if - order and result channels of the price-time order matcher
// valid/ready channels, one transfer per edge with valid and ready high
// ============================================================================
interface ptom_in_if import ptom_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     order_id;
    logic [PRICE_W-1:0]  limit_price;
    logic [TIME_W-1:0]   arrival_time;

    modport source (output valid, output mode, output order_id, output limit_price,
                    output arrival_time, input ready);
    modport sink (input valid, input mode, input order_id, input limit_price,
                  input arrival_time, output ready);
endinterface

interface ptom_out_if import ptom_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     buyer_id;
    logic [ID_W-1:0]     seller_id;
    logic [PRICE_W-1:0]  fill_price;

    modport source (output valid, output status, output buyer_id, output seller_id,
                    output fill_price, input ready);
    modport sink (input valid, input status, input buyer_id, input seller_id,
                  input fill_price, output ready);
endinterface

/* sv/ptom_cmp.sv */
// ============================================================================
// ptom_cmp - shared compare unit
// qualifies one table entry against the order and the best entry so far
// ============================================================================
module ptom_cmp import ptom_pkg::*; (
    input  t_cmp_op            i_op,
    input  t_entry             i_entry,
    input  logic [PRICE_W-1:0] i_lim,
    input  logic [ID_W-1:0]    i_key_id,
    input  logic               i_best_vld,
    input  t_entry             i_best,
    output logic               o_take
);

    logic ok;
    logic better;
    logic same_px;
    logic earlier;

    assign same_px = (i_entry.price == i_best.price);
    assign earlier = (i_entry.stamp < i_best.stamp);

    always_comb begin
        ok     = 1'b0;
        better = 1'b0;
        case (i_op)
            CMP_ASK: begin
                ok     = (i_entry.price <= i_lim);
                better = !i_best_vld || (i_entry.price < i_best.price) ||
                         (same_px && earlier);
            end
            CMP_BID: begin
                ok     = (i_entry.price >= i_lim);
                better = !i_best_vld || (i_entry.price > i_best.price) ||
                         (same_px && earlier);
            end
            CMP_ID: begin
                ok     = (i_entry.ident == i_key_id);
                better = !i_best_vld;
            end
            default: begin
                ok     = 1'b0;
                better = 1'b0;
            end
        endcase
    end

    assign o_take = ok && better;

endmodule

/* sv/ptom_table.sv */
// ============================================================================
// ptom_table - one side of the book
// entry memory oldest at address 0, newest at count-1, with its fill count
// ============================================================================
module ptom_table import ptom_pkg::*; #(
    parameter  int DEPTH = BOOK_DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tbl_ctl      i_ctl,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    output t_entry        o_rd_data,
    output logic [CW-1:0] o_count
);

    t_entry        r_mem [DEPTH];
    t_entry        r_rd_data;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.inc) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.dec) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;

endmodule

/* sv/price_time_order_matcher.sv */
// ============================================================================
// price_time_order_matcher - bounded limit order book with price-time matching
// sequencer over two entry memories and one shared compare unit
// ============================================================================
// i_ord carries one order per transfer: buy, sell or cancel by id. o_res
// carries exactly one result per order: status, buyer id, seller id, price.
// ready on i_ord is high only while the sequencer is idle; one order is
// worked at a time. A buy, sell or cancel scans one side for the best entry,
// decides, closes the gap when an entry is removed by moving each newer entry
// down one place, and then hands over the result; the next order is taken
// once the result is loaded. A cancel that misses the bids also scans the
// asks; the longest case is a cancel that finds its id at the oldest ask.
// An unknown mode skips the scan and goes straight to handing over a result.
// The memory read port, one entry per cycle, paces the scan and the gap.
// Reset empties both sides by clearing their fill counts; no clearing pass
// is needed and the block is ready on the first cycle after reset.
// The result waits in an output register; while o_res is stalled the block
// holds its finished result and takes no new order until it is moved there.
// ============================================================================
module price_time_order_matcher import ptom_pkg::*; #(
    parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    ptom_in_if.sink   i_ord,
    ptom_out_if.source o_res
);

    localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(BOOK_DEPTH);

    t_state               r_state, n_state;
    logic [MODE_W-1:0]    r_mode, n_mode;
    logic [ID_W-1:0]      r_oid, n_oid;
    logic [PRICE_W-1:0]   r_lim, n_lim;
    logic [TIME_W-1:0]    r_tim, n_tim;
    logic                 r_side, n_side;
    logic                 r_issuing, n_issuing;
    logic [AW-1:0]        r_issue_addr, n_issue_addr;
    logic [CW-1:0]        r_mv, n_mv;
    logic                 r_rd_vld, n_rd_vld;
    logic [AW-1:0]        r_rd_addr, n_rd_addr;
    logic                 r_best_vld, n_best_vld;
    t_entry               r_best, n_best;
    logic [AW-1:0]        r_best_addr, n_best_addr;
    logic [STATUS_W-1:0]  r_res_status, n_res_status;
    logic [ID_W-1:0]      r_res_buyer, n_res_buyer;
    logic [ID_W-1:0]      r_res_seller, n_res_seller;
    logic [PRICE_W-1:0]   r_res_fill, n_res_fill;
    logic                 r_out_vld, n_out_vld;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;
    logic [ID_W-1:0]      r_out_buyer, n_out_buyer;
    logic [ID_W-1:0]      r_out_seller, n_out_seller;
    logic [PRICE_W-1:0]   r_out_fill, n_out_fill;

    t_tbl_ctl      side_ctl, own_ctl, bid_ctl, ask_ctl;
    logic [AW-1:0] tbl_rd_addr, tbl_wr_addr;
    t_entry        tbl_wr_data;
    t_entry        bid_rd, ask_rd, side_rd;
    logic [CW-1:0] bid_cnt, ask_cnt, side_cnt, own_cnt, side_m1;
    t_cmp_op       cmp_op;
    logic          cmp_take;
    logic          in_fire;
    logic          out_free;
    logic          mv_more;

    assign in_fire  = i_ord.valid && i_ord.ready;
    assign out_free = !r_out_vld || o_res.ready;
    assign side_rd  = (r_side == SIDE_ASK) ? ask_rd : bid_rd;
    assign side_cnt = (r_side == SIDE_ASK) ? ask_cnt : bid_cnt;
    assign own_cnt  = (r_side == SIDE_ASK) ? bid_cnt : ask_cnt;
    assign side_m1  = side_cnt - CW'(1);
    assign mv_more  = (r_mv < side_cnt);
    assign cmp_op   = (r_mode == MODE_CANCEL) ? CMP_ID :
                      ((r_side == SIDE_ASK) ? CMP_ASK : CMP_BID);
    assign bid_ctl  = (r_side == SIDE_ASK) ? own_ctl : side_ctl;
    assign ask_ctl  = (r_side == SIDE_ASK) ? side_ctl : own_ctl;

    ptom_table #(.DEPTH(BOOK_DEPTH)) u_bid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (bid_ctl),
        .i_rd_addr (tbl_rd_addr),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .o_rd_data (bid_rd),
        .o_count   (bid_cnt)
    );

    ptom_table #(.DEPTH(BOOK_DEPTH)) u_ask (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ask_ctl),
        .i_rd_addr (tbl_rd_addr),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .o_rd_data (ask_rd),
        .o_count   (ask_cnt)
    );

    ptom_cmp u_cmp (
        .i_op       (cmp_op),
        .i_entry    (side_rd),
        .i_lim      (r_lim),
        .i_key_id   (r_oid),
        .i_best_vld (r_best_vld),
        .i_best     (r_best),
        .o_take     (cmp_take)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_ord.mode inside {MODE_BUY, MODE_SELL, MODE_CANCEL}) begin
                        n_state = ST_START;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_START: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!r_issuing && !r_rd_vld) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_best_vld) begin
                    n_state = ST_COMPACT;
                end else if (r_mode == MODE_CANCEL && r_side == SIDE_BID) begin
                    n_state = ST_START;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_COMPACT: begin
                if (!mv_more && !r_rd_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and table control
    always_comb begin
        n_mode       = r_mode;
        n_oid        = r_oid;
        n_lim        = r_lim;
        n_tim        = r_tim;
        n_side       = r_side;
        n_issuing    = r_issuing;
        n_issue_addr = r_issue_addr;
        n_mv         = r_mv;
        n_rd_vld     = r_rd_vld;
        n_rd_addr    = r_rd_addr;
        n_best_vld   = r_best_vld;
        n_best       = r_best;
        n_best_addr  = r_best_addr;
        n_res_status = r_res_status;
        n_res_buyer  = r_res_buyer;
        n_res_seller = r_res_seller;
        n_res_fill   = r_res_fill;
        n_out_vld    = r_out_vld && !o_res.ready;
        n_out_status = r_out_status;
        n_out_buyer  = r_out_buyer;
        n_out_seller = r_out_seller;
        n_out_fill   = r_out_fill;
        side_ctl     = '0;
        own_ctl      = '0;
        tbl_rd_addr  = '0;
        tbl_wr_addr  = '0;
        tbl_wr_data  = r_best;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_mode       = i_ord.mode;
                    n_oid        = i_ord.order_id;
                    n_lim        = i_ord.limit_price;
                    n_tim        = i_ord.arrival_time;
                    n_side       = (i_ord.mode == MODE_BUY) ? SIDE_ASK : SIDE_BID;
                    n_best_vld   = 1'b0;
                    n_res_status = STAT_NOTFOUND;
                    n_res_buyer  = '0;
                    n_res_seller = '0;
                    n_res_fill   = '0;
                end
            end
            ST_START: begin
                n_issuing    = (side_cnt != '0);
                n_issue_addr = side_m1[AW-1:0];
                n_rd_vld     = 1'b0;
            end
            ST_SCAN: begin
                if (r_issuing) begin
                    side_ctl.rd_en = 1'b1;
                    tbl_rd_addr    = r_issue_addr;
                    n_rd_vld       = 1'b1;
                    n_rd_addr      = r_issue_addr;
                    if (r_issue_addr == '0) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_issue_addr = r_issue_addr - AW'(1);
                    end
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld && cmp_take) begin
                    n_best_vld  = 1'b1;
                    n_best      = side_rd;
                    n_best_addr = r_rd_addr;
                end
            end
            ST_DECIDE: begin
                n_rd_vld = 1'b0;
                if (r_best_vld) begin
                    n_mv = CW'(r_best_addr) + CW'(1);
                    if (r_mode == MODE_CANCEL) begin
                        n_res_status = STAT_CANCELLED;
                    end else begin
                        n_res_status = STAT_MATCHED;
                        n_res_fill   = r_best.price;
                        if (r_side == SIDE_ASK) begin
                            n_res_buyer  = r_oid;
                            n_res_seller = r_best.ident;
                        end else begin
                            n_res_buyer  = r_best.ident;
                            n_res_seller = r_oid;
                        end
                    end
                end else if (r_mode == MODE_CANCEL) begin
                    if (r_side == SIDE_BID) begin
                        n_side = SIDE_ASK;
                    end
                end else if (own_cnt == FULL_CNT) begin
                    n_res_status = STAT_FULL;
                end else begin
                    own_ctl.wr_en     = 1'b1;
                    own_ctl.inc       = 1'b1;
                    tbl_wr_addr       = own_cnt[AW-1:0];
                    tbl_wr_data.ident = r_oid;
                    tbl_wr_data.price = r_lim;
                    tbl_wr_data.stamp = r_tim;
                    n_res_status      = STAT_RESTED;
                end
            end
            ST_COMPACT: begin
                if (mv_more) begin
                    side_ctl.rd_en = 1'b1;
                    tbl_rd_addr    = r_mv[AW-1:0];
                    n_rd_vld       = 1'b1;
                    n_rd_addr      = r_mv[AW-1:0];
                    n_mv           = r_mv + CW'(1);
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld) begin
                    side_ctl.wr_en = 1'b1;
                    tbl_wr_addr    = r_rd_addr - AW'(1);
                    tbl_wr_data    = side_rd;
                end
                if (!mv_more && !r_rd_vld) begin
                    side_ctl.dec = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_buyer  = r_res_buyer;
                    n_out_seller = r_res_seller;
                    n_out_fill   = r_res_fill;
                end
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_issuing  <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_issuing  <= n_issuing;
            r_rd_vld   <= n_rd_vld;
            r_best_vld <= n_best_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_oid        <= n_oid;
        r_lim        <= n_lim;
        r_tim        <= n_tim;
        r_side       <= n_side;
        r_issue_addr <= n_issue_addr;
        r_mv         <= n_mv;
        r_rd_addr    <= n_rd_addr;
        r_best       <= n_best;
        r_best_addr  <= n_best_addr;
        r_res_status <= n_res_status;
        r_res_buyer  <= n_res_buyer;
        r_res_seller <= n_res_seller;
        r_res_fill   <= n_res_fill;
        r_out_status <= n_out_status;
        r_out_buyer  <= n_out_buyer;
        r_out_seller <= n_out_seller;
        r_out_fill   <= n_out_fill;
    end

    assign i_ord.ready      = (r_state == ST_IDLE);
    assign o_res.valid      = r_out_vld;
    assign o_res.status     = r_out_status;
    assign o_res.buyer_id   = r_out_buyer;
    assign o_res.seller_id  = r_out_seller;
    assign o_res.fill_price = r_out_fill;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bid_cnt <= FULL_CNT) && (ask_cnt <= FULL_CNT))
        else $error("book side count beyond depth");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_vld && !o_res.ready) |=> (r_state == ST_DONE))
        else $error("result dropped while output stalled");

    a_buy_price: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE && r_best_vld && r_mode == MODE_BUY)
        |-> (r_best.price <= r_lim))
        else $error("buy matched an ask above its limit");

    a_compact_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMPACT && n_state == ST_DONE && r_side == SIDE_BID)
        |=> (bid_cnt == $past(bid_cnt) - CW'(1)))
        else $error("bid removal did not shrink the side");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench of the price-time order matcher
// Drives buy, sell and cancel orders through the order channel: a directed
// table first (empty book, price and id extremes, time and arrival ties, a
// full table on each side, duplicate ids), then random phases with a mix of
// order kinds, price bands and idle patterns. An in-bench model of both
// tables predicts untyped results, and results are compared field by field.
// ============================================================================
module tb_top import ptom_pkg::*; ();

    localparam int DEPTH       = BOOK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int DRAIN_WAIT  = 60;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [TIME_W-1:0]  stamp;
    } t_order;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     buyer;
        logic [ID_W-1:0]     seller;
        logic [PRICE_W-1:0]  fill;
    } t_outcome;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [TIME_W-1:0]  stamp;
        logic [7:0]         reps;
        logic               typed;
        t_outcome           res;
    } t_plan_row;

    localparam int PLAN_ROWS = 24;
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        '{MODE_CANCEL, 31'd5, 32'd0, 32'd0, 8'd1, 1'b1, '{STAT_NOTFOUND, 31'd0, 31'd0, 32'd0}},
        '{MODE_NONE, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 1'b1,
          '{STAT_NOTFOUND, 31'd0, 31'd0, 32'd0}},
        '{MODE_BUY, 31'h7FFF_FFFF, 32'd0, 32'd0, 8'd1, 1'b1,
          '{STAT_RESTED, 31'd0, 31'd0, 32'd0}},
        '{MODE_SELL, 31'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 1'b1,
          '{STAT_RESTED, 31'd0, 31'd0, 32'd0}},
        '{MODE_BUY, 31'd1, 32'hFFFF_FFFF, 32'd5, 8'd1, 1'b1,
          '{STAT_MATCHED, 31'd1, 31'd0, 32'hFFFF_FFFF}},
        '{MODE_SELL, 31'd2, 32'd0, 32'd7, 8'd1, 1'b1,
          '{STAT_MATCHED, 31'h7FFF_FFFF, 31'd2, 32'd0}},
        // equal prices, arrival ties, newest wins a full tie
        '{MODE_SELL, 31'd400, 32'd500, 32'd9, 8'd1, 1'b0, '0},
        '{MODE_SELL, 31'd401, 32'd500, 32'd3, 8'd1, 1'b0, '0},
        '{MODE_SELL, 31'd402, 32'd500, 32'd3, 8'd1, 1'b0, '0},
        '{MODE_SELL, 31'd403, 32'd501, 32'd0, 8'd1, 1'b0, '0},
        '{MODE_BUY, 31'd10, 32'd600, 32'd20, 8'd1, 1'b0, '0},
        '{MODE_BUY, 31'd11, 32'd600, 32'd21, 8'd1, 1'b0, '0},
        '{MODE_BUY, 31'd12, 32'd499, 32'd22, 8'd1, 1'b0, '0},
        // bid table fills up, last one rejected
        '{MODE_BUY, 31'd100, 32'd100, 32'd50, 8'd16, 1'b0, '0},
        '{MODE_BUY, 31'd200, 32'd10, 32'd1, 8'd1, 1'b1, '{STAT_FULL, 31'd0, 31'd0, 32'd0}},
        '{MODE_SELL, 31'd300, 32'd105, 32'd0, 8'd1, 1'b0, '0},
        // same id on both sides
        '{MODE_SELL, 31'd104, 32'hFFFF_FFFF, 32'd0, 8'd1, 1'b0, '0},
        '{MODE_CANCEL, 31'd104, 32'd0, 32'd0, 8'd1, 1'b1,
          '{STAT_CANCELLED, 31'd0, 31'd0, 32'd0}},
        '{MODE_CANCEL, 31'd104, 32'd0, 32'd0, 8'd1, 1'b1,
          '{STAT_CANCELLED, 31'd0, 31'd0, 32'd0}},
        '{MODE_CANCEL, 31'd104, 32'd0, 32'd0, 8'd1, 1'b1,
          '{STAT_NOTFOUND, 31'd0, 31'd0, 32'd0}},
        // ask table fills up
        '{MODE_SELL, 31'd500, 32'hFFFF_FF00, 32'hFFFF_FFFF, 8'd17, 1'b0, '0},
        '{MODE_CANCEL, 31'd505, 32'd0, 32'd0, 8'd1, 1'b0, '0},
        '{MODE_BUY, 31'd20, 32'd501, 32'd0, 8'd1, 1'b0, '0},
        '{MODE_NONE, 31'd0, 32'd0, 32'd0, 8'd1, 1'b1, '{STAT_NOTFOUND, 31'd0, 31'd0, 32'd0}}
    };

    logic clk;
    logic rst_n;

    ptom_in_if  ord_if ();
    ptom_out_if res_if ();

    price_time_order_matcher #(
        .BOOK_DEPTH(DEPTH)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_ord  (ord_if),
        .o_res  (res_if)
    );

    t_entry   bid_q[$];
    t_entry   ask_q[$];
    t_outcome outcome_q[$];

    int send_gap_max = 19;
    int recv_gap_max = 19;
    int orders_sent  = 0;
    int results_seen = 0;
    int err_cnt      = 0;
    int stat_seen [8];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL price_time_order_matcher");
        $finish;
    end

    // lowest ask at or below lim, earliest arrival, newest on a full tie
    function automatic int best_ask(logic [PRICE_W-1:0] lim);
        int pick;
        pick = -1;
        foreach (ask_q[k]) begin
            if (ask_q[k].price <= lim) begin
                if (pick < 0 || ask_q[k].price < ask_q[pick].price ||
                    (ask_q[k].price == ask_q[pick].price &&
                     ask_q[k].stamp < ask_q[pick].stamp))
                    pick = k;
            end
        end
        return pick;
    endfunction

    function automatic int best_bid(logic [PRICE_W-1:0] lim);
        int pick;
        pick = -1;
        foreach (bid_q[k]) begin
            if (bid_q[k].price >= lim) begin
                if (pick < 0 || bid_q[k].price > bid_q[pick].price ||
                    (bid_q[k].price == bid_q[pick].price &&
                     bid_q[k].stamp < bid_q[pick].stamp))
                    pick = k;
            end
        end
        return pick;
    endfunction

    function automatic t_outcome book_apply(t_order o);
        t_outcome r;
        t_entry   e;
        int       pos;
        r   = '0;
        r.status = STAT_NOTFOUND;
        e   = '{ident: o.id, price: o.price, stamp: o.stamp};
        pos = -1;
        case (o.mode)
            MODE_BUY: begin
                pos = best_ask(o.price);
                if (pos >= 0) begin
                    r = '{STAT_MATCHED, o.id, ask_q[pos].ident, ask_q[pos].price};
                    ask_q.delete(pos);
                end else if (bid_q.size() < DEPTH) begin
                    bid_q.push_front(e);
                    r.status = STAT_RESTED;
                end else begin
                    r.status = STAT_FULL;
                end
            end
            MODE_SELL: begin
                pos = best_bid(o.price);
                if (pos >= 0) begin
                    r = '{STAT_MATCHED, bid_q[pos].ident, o.id, bid_q[pos].price};
                    bid_q.delete(pos);
                end else if (ask_q.size() < DEPTH) begin
                    ask_q.push_front(e);
                    r.status = STAT_RESTED;
                end else begin
                    r.status = STAT_FULL;
                end
            end
            MODE_CANCEL: begin
                foreach (bid_q[k]) begin
                    if (pos < 0 && bid_q[k].ident == o.id)
                        pos = k;
                end
                if (pos >= 0) begin
                    bid_q.delete(pos);
                    r.status = STAT_CANCELLED;
                end else begin
                    foreach (ask_q[k]) begin
                        if (pos < 0 && ask_q[k].ident == o.id)
                            pos = k;
                    end
                    if (pos >= 0) begin
                        ask_q.delete(pos);
                        r.status = STAT_CANCELLED;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_order rand_order(int buy_pct, int cxl_pct, logic [PRICE_W-1:0] mid);
        t_order o;
        int     pick;
        int     total;
        o.stamp = ($urandom_range(0, 1) == 0) ? TIME_W'($urandom_range(0, 3)) : $urandom;
        if ($urandom_range(0, 9) < 6)
            o.id = ID_W'($urandom_range(0, 31));
        else
            o.id = ID_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 85)
            o.price = mid - 32'd20 + PRICE_W'($urandom_range(0, 40));
        else if (pick < 93)
            o.price = ($urandom_range(0, 1) == 0) ? '0 : '1;
        else
            o.price = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            o.mode = MODE_NONE;
        end else if (pick < 2 + cxl_pct) begin
            o.mode = MODE_CANCEL;
            total  = bid_q.size() + ask_q.size();
            if (total > 0 && $urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, total - 1);
                o.id = (pick < bid_q.size()) ? bid_q[pick].ident :
                                               ask_q[pick - bid_q.size()].ident;
            end
        end else begin
            o.mode = ($urandom_range(0, 99) < buy_pct) ? MODE_BUY : MODE_SELL;
        end
        return o;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_order(input t_order o, input logic typed, input t_outcome typed_res);
        int       gap;
        t_outcome pred;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            ord_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ord_if.valid        <= 1'b1;
        ord_if.mode         <= o.mode;
        ord_if.order_id     <= o.id;
        ord_if.limit_price  <= o.price;
        ord_if.arrival_time <= o.stamp;
        do @(posedge clk); while (!ord_if.ready);
        pred = book_apply(o);
        outcome_q.push_back(typed ? typed_res : pred);
        orders_sent++;
        @(negedge clk);
    endtask

    task automatic drain_book_results();
        ord_if.valid <= 1'b0;
        @(negedge clk);
        while (outcome_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic take_result();
        t_outcome got;
        t_outcome want;
        got = '{res_if.status, res_if.buyer_id, res_if.seller_id, res_if.fill_price};
        results_seen++;
        stat_seen[got.status]++;
        if (outcome_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("[%0t] result with nothing pending: %s %0d buyer %0d seller %0d fill %0d",
                         $realtime, "status", got.status, got.buyer, got.seller,
                         got.fill);
            return;
        end
        want = outcome_q.pop_front();
        if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
                $display("[%0t] mismatch on result %0d", $realtime, results_seen);
                $display("    expected status %0d buyer %0d seller %0d fill %0d",
                         want.status, want.buyer, want.seller, want.fill);
                $display("    actual   status %0d buyer %0d seller %0d fill %0d",
                         got.status, got.buyer, got.seller, got.fill);
            end
        end
    endtask

    initial begin
        int stall;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = $urandom_range(0, recv_gap_max);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            take_result();
            @(negedge clk);
        end
    end

    initial begin
        t_order         o;
        int             counted;
        int             buy_pct;
        int             cxl_pct;
        logic [PRICE_W-1:0] mid;
        rst_n               = 1'b0;
        ord_if.valid        = 1'b0;
        ord_if.mode         = MODE_BUY;
        ord_if.order_id     = '0;
        ord_if.limit_price  = '0;
        ord_if.arrival_time = '0;
        foreach (stat_seen[k])
            stat_seen[k] = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (PLAN[r]) begin
            for (int k = 0; k < PLAN[r].reps; k++) begin
                o = '{PLAN[r].mode, PLAN[r].id + ID_W'(k), PLAN[r].price + PRICE_W'(k),
                      PLAN[r].stamp};
                send_order(o, PLAN[r].typed, PLAN[r].res);
            end
        end
        drain_book_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            buy_pct      = (ph % 3 == 0) ? 50 : (ph % 3 == 1) ? 80 : 20;
            cxl_pct      = $urandom_range(5, 30);
            send_gap_max = (ph == 2 || ph == 5) ? 0 : 19;
            recv_gap_max = (ph == 3 || ph == 5) ? 0 : 19;
            if (ph == 1)
                mid = 32'd20;
            else if (ph == 4)
                mid = 32'hFFFF_FFE0;
            else
                mid = PRICE_W'($urandom_range(1000, 32'h7FFF_FFFF));
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                o = rand_order(buy_pct, cxl_pct, mid);
                send_order(o, 1'b0, '0);
                if (o.mode != MODE_NONE)
                    counted++;
            end
            drain_book_results();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        $display("orders sent %0d, results checked %0d, mismatches %0d",
                 orders_sent, results_seen, err_cnt);
        $display("rested %0d, matched %0d, cancelled %0d, not found %0d, rejected full %0d",
                 stat_seen[STAT_RESTED], stat_seen[STAT_MATCHED], stat_seen[STAT_CANCELLED],
                 stat_seen[STAT_NOTFOUND], stat_seen[STAT_FULL]);
        if (err_cnt == 0 && outcome_q.size() == 0)
            $display("PASS price_time_order_matcher");
        else
            $display("FAIL price_time_order_matcher");
        $finish;
    end

endmodule
